/* rtl/vn_pkg.sv */
// Package for vector3_normalize: payload structs, widths, register map and pipeline depths.
// No dependencies.
package vn_pkg;

    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned DIV_STEPS  = 31;
    localparam logic [30:0] MIN_LENGTH_RST = 31'd0;
    localparam logic [1:0]  ADDR_MIN_LENGTH = 2'd0;

    typedef struct packed {
        logic signed [31:0] comp_x;
        logic signed [31:0] comp_y;
        logic signed [31:0] comp_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic               degenerate;
    } t_vec_out;

endpackage

/* rtl/vector3_normalize.sv */
// vector3_normalize: pipelined 3-D vector normalization.
// One request accepted per cycle; o_done flags each result as it leaves the output stage.
// Stages: abs/square (2), sum (1), one sqrt bit per stage (32), compare (1),
// one quotient bit per stage (31), saturate/output (1). busy is always low.
// Reset (i_rst_n low, synchronous) clears valid bits and min_length.
// Depends on vn_pkg.
module vector3_normalize (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  vn_pkg::t_vec_in   i_vec,
    output logic              o_done,
    output vn_pkg::t_vec_out  o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int unsigned NS = vn_pkg::SQRT_STEPS;
    localparam int unsigned ND = vn_pkg::DIV_STEPS;

    logic [30:0] r_min_length;
    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign prdata = (paddr == vn_pkg::ADDR_MIN_LENGTH) ? {1'b0, r_min_length} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= vn_pkg::MIN_LENGTH_RST;
        end else if (psel && penable && pwrite && paddr == vn_pkg::ADDR_MIN_LENGTH) begin
            r_min_length <= pwdata[30:0];
        end
    end

    // stage A: magnitudes
    logic        r_va;
    logic [31:0] r_mag_a [3];
    logic [2:0]  r_neg_a;
    // stage B: squares
    logic        r_vb;
    logic [63:0] r_sq_b [3];
    logic [31:0] r_mag_b [3];
    logic [2:0]  r_neg_b;
    // stage C: sum
    logic        r_vc;
    logic [65:0] r_sum_c;
    logic [31:0] r_mag_c [3];
    logic [2:0]  r_neg_c;

    logic [31:0] w_in [3];
    assign w_in[0] = i_vec.comp_x;
    assign w_in[1] = i_vec.comp_y;
    assign w_in[2] = i_vec.comp_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= start;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_neg_a[i]  <= w_in[i][31];
            r_mag_a[i]  <= w_in[i][31] ? (~w_in[i] + 32'd1) : w_in[i];
            r_sq_b[i]   <= 64'(r_mag_a[i]) * 64'(r_mag_a[i]);
            r_mag_b[i]  <= r_mag_a[i];
            r_mag_c[i]  <= r_mag_b[i];
        end
        r_neg_b <= r_neg_a;
        r_neg_c <= r_neg_b;
        r_sum_c <= 66'(r_sq_b[0]) + 66'(r_sq_b[1]) + 66'(r_sq_b[2]);
    end

    // square root: one result bit per stage, restoring
    logic        r_vs  [NS+1];
    logic [65:0] r_rem [NS+1];
    logic [31:0] r_root[NS+1];
    logic [65:0] r_rad [NS+1];
    logic [31:0] r_mag_s [NS+1][3];
    logic [2:0]  r_neg_s [NS+1];

    always_comb begin
        r_vs[0]    = r_vc;
        r_rem[0]   = 66'd0;
        r_root[0]  = 32'd0;
        r_rad[0]   = r_sum_c;
        r_mag_s[0] = r_mag_c;
        r_neg_s[0] = r_neg_c;
    end

    for (genvar s = 0; s < NS; s++) begin : g_sqrt
        logic [65:0] w_r;
        logic [65:0] w_t;
        assign w_r = {r_rem[s][63:0], r_rad[s][63:62]};
        assign w_t = {32'd0, r_root[s], 2'b01};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[s+1] <= 1'b0;
            end else begin
                r_vs[s+1] <= r_vs[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_r >= w_t) begin
                r_rem[s+1]  <= w_r - w_t;
                r_root[s+1] <= {r_root[s][30:0], 1'b1};
            end else begin
                r_rem[s+1]  <= w_r;
                r_root[s+1] <= {r_root[s][30:0], 1'b0};
            end
            r_rad[s+1]   <= {r_rad[s][63:0], 2'b00};
            r_mag_s[s+1] <= r_mag_s[s];
            r_neg_s[s+1] <= r_neg_s[s];
        end
    end

    // compare stage
    logic        r_vm;
    logic        r_deg_m;
    logic [31:0] r_m_m;
    logic [31:0] r_mag_m [3];
    logic [2:0]  r_neg_m;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= r_vs[NS];
        end
    end
    always_ff @(posedge i_clk) begin
        r_deg_m <= r_root[NS] <= {1'b0, r_min_length};
        r_m_m   <= r_root[NS];
        r_mag_m <= r_mag_s[NS];
        r_neg_m <= r_neg_s[NS];
    end

    // division: quotient of mag*2^30 / m, bits 30..0 one per stage.
    // Any quotient >= 2^31 would need mag >= 2m, impossible since m >= mag.
    logic        r_vd  [ND+1];
    logic [32:0] r_drm [ND+1][3];
    logic [30:0] r_q   [ND+1][3];
    logic [31:0] r_m_d [ND+1];
    logic        r_deg_d [ND+1];
    logic [2:0]  r_neg_d [ND+1];

    always_comb begin
        r_vd[0]    = r_vm;
        r_m_d[0]   = r_m_m;
        r_deg_d[0] = r_deg_m;
        r_neg_d[0] = r_neg_m;
        for (int i = 0; i < 3; i++) begin
            r_drm[0][i]   = 33'd0;
            r_q[0][i]     = 31'd0;
        end
    end

    // dividend = mag << 30 (62 bits): the upper 32 bits are mag itself, so the
    // first step seeds the remainder with mag; later steps shift in zeros.
    for (genvar s = 0; s < ND; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[s+1] <= 1'b0;
            end else begin
                r_vd[s+1] <= r_vd[s];
            end
        end
        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [32:0] w_r;
            always_comb begin
                if (s == 0) begin
                    w_r = {1'b0, r_mag_m[i]};
                end else begin
                    w_r = {r_drm[s][i][31:0], 1'b0};
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_r >= {1'b0, r_m_d[s]}) begin
                    r_drm[s+1][i] <= w_r - {1'b0, r_m_d[s]};
                    r_q[s+1][i]   <= {r_q[s][i][29:0], 1'b1};
                end else begin
                    r_drm[s+1][i] <= w_r;
                    r_q[s+1][i]   <= {r_q[s][i][29:0], 1'b0};
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_m_d[s+1]   <= r_m_d[s];
            r_deg_d[s+1] <= r_deg_d[s];
            r_neg_d[s+1] <= r_neg_d[s];
        end
    end

    // The first step compares mag (= mag*2^30 >> 30) against m, giving q bit 30,
    // subsequent steps give bits 29..0: 31 steps total.

    logic             r_done;
    vn_pkg::t_vec_out r_res;
    logic [31:0]      w_u [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [31:0] q;
            q = (r_q[ND][i] > 31'h40000000) ? 32'h40000000 : {1'b0, r_q[ND][i]};
            if (r_deg_d[ND]) begin
                w_u[i] = 32'd0;
            end else begin
                w_u[i] = r_neg_d[ND][i] ? (~q + 32'd1) : q;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vd[ND];
        end
    end
    always_ff @(posedge i_clk) begin
        r_res.unit_x     <= w_u[0];
        r_res.unit_y     <= w_u[1];
        r_res.unit_z     <= w_u[2];
        r_res.degenerate <= r_deg_d[ND];
    end
    assign o_done = r_done;
    assign o_res  = r_res;

    a_zero_on_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.degenerate |-> o_res.unit_x == 32'd0 && o_res.unit_y == 32'd0
            && o_res.unit_z == 32'd0)
        else $error("degenerate result not zero");
    a_no_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_done_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("done right after reset");
endmodule
